// ----- src/life_generation_engine_macros.svh -----
// Assertion macros for the life generation engine.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lge_pkg.sv -----
// Types, codes and defaults shared by the life generation engine.
package lge_pkg;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 128;
  localparam logic [7:0] RESET_COLUMNS = 8'd106;
  localparam logic [7:0] RESET_ROWS    = 8'd80;
  localparam logic [7:0] MIN_SIZE      = 8'd3;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_ALIVE = 2'd1;
  localparam logic [1:0] CELL_DIED  = 2'd2;
  localparam logic [1:0] CELL_BAD   = 2'd3;

  localparam logic [1:0] CHANGE_UNCHANGED = 2'd3;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] column;
    logic [6:0] row;
    logic [1:0] cell_value;
  } in_t;

  typedef struct packed {
    logic [1:0] cell_state;
    logic [1:0] change_code;
    logic       range_error;
  } out_t;

endpackage

// ----- src/life_generation_engine.sv -----
// Top level of the life generation engine: command sequencer over two grid banks.
//
//   channel   direction  handshake              payload
//   request   in         in_valid_i/in_ready_o  in_data_i (command, column, row, cell_value)
//   result    out        out_valid_o/out_ready_i out_data_o (cell_state, change_code, range_error)
//   config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// A read waits in ST_READ for the registered RAM read data; write and out-of-range requests do not.
// A step streams every cell through the window.
// A clear, and the clearing pass after reset, each write every cell of both banks to empty.
// A finished result waits in the output register while the next request is taken.
module life_generation_engine #(
  parameter int MAX_COLUMNS = lge_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lge_pkg::DEF_MAX_ROWS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lge_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lge_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import lge_pkg::*;
  `include "life_generation_engine_macros.svh"

  localparam int N   = MAX_COLUMNS * MAX_ROWS;
  localparam int AW  = $clog2(N);
  localparam int FW  = $clog2(N + MAX_ROWS + 2);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CSW = $clog2(MAX_COLUMNS + 1);
  localparam int RSW = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_READ, ST_STEP, ST_CLEAR, ST_HOLD
  } st_e;

  st_e            state_q, state_d;
  logic           bank_q, bank_d;
  logic [7:0]     cols_q, cols_d, rows_q, rows_d;
  logic [AW-1:0]  sweep_q, sweep_d;
  logic [FW-1:0]  f_q, f_d, s1_idx_q;
  logic           feed_q, feed_d, s1_v_q, s1_in_q, wv_q;
  logic [AW-1:0]  wa_q, wa_d;
  logic [CIW-1:0] wc_q, wc_d;
  logic [RIW-1:0] wr_q, wr_d;
  out_t           hold_q, hold_d, out_q, out_d, res;
  logic           out_valid_q, out_valid_d, res_v;

  logic           we_a, we_b;
  logic [AW-1:0]  waddr, raddr, in_addr;
  logic [1:0]     wdata, rdata_a, rdata_b, now_v, prev_v, win_next, in_val;
  logic [CSW-1:0] cols_eff;
  logic [RSW-1:0] rows_eff;
  logic           in_grid, accept, interior, step_done;

  lge_ram #(.WIDTH(2), .DEPTH(N)) u_bank_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata_a)
  );
  lge_ram #(.WIDTH(2), .DEPTH(N)) u_bank_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata_b)
  );
  lge_window #(.MAX_ROWS(MAX_ROWS)) u_window (
    .clk_i, .shift_i(s1_v_q), .alive_i(s1_in_q && (now_v == CELL_ALIVE)), .next_o(win_next)
  );

  always_comb begin
    if (cols_q < MIN_SIZE) cols_eff = CSW'(MIN_SIZE);
    else if (32'(cols_q) > MAX_COLUMNS) cols_eff = CSW'(MAX_COLUMNS);
    else cols_eff = CSW'(cols_q);
    if (rows_q < MIN_SIZE) rows_eff = RSW'(MIN_SIZE);
    else if (32'(rows_q) > MAX_ROWS) rows_eff = RSW'(MAX_ROWS);
    else rows_eff = RSW'(rows_q);
  end

  assign in_grid   = (in_data_i.column < cols_eff) && (in_data_i.row < rows_eff);
  assign in_addr   = AW'(AW'(in_data_i.column) * AW'(MAX_ROWS)) + AW'(in_data_i.row);
  assign in_val    = (in_data_i.cell_value == CELL_BAD) ? CELL_EMPTY : in_data_i.cell_value;
  assign now_v     = bank_q ? rdata_b : rdata_a;
  assign prev_v    = bank_q ? rdata_a : rdata_b;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign interior  = (wc_q != '0) && ((CSW'(wc_q) + CSW'(1)) < cols_eff)
                  && (wr_q != '0) && ((RSW'(wr_q) + RSW'(1)) < rows_eff);
  assign step_done = (state_q == ST_STEP) && wv_q && (wa_q == AW'(N - 1));

  always_comb begin
    state_d = state_q;
    bank_d = bank_q;
    cols_d = cols_q;
    rows_d = rows_q;
    sweep_d = sweep_q;
    f_d = f_q;
    feed_d = feed_q;
    wa_d = wa_q;
    wc_d = wc_q;
    wr_d = wr_q;
    hold_d = hold_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_v = 1'b0;
    res = '0;
    we_a = 1'b0;
    we_b = 1'b0;
    waddr = sweep_q;
    wdata = CELL_EMPTY;
    raddr = in_addr;

    if (cfg_we_i) begin
      if (cfg_index_i == REG_GRID_COLUMNS) cols_d = cfg_data_i;
      if (cfg_index_i == REG_GRID_ROWS) rows_d = cfg_data_i;
    end

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        we_a = 1'b1;
        we_b = 1'b1;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(N - 1)) begin
          sweep_d = '0;
          bank_d = 1'b0;
          if (state_q == ST_INIT) state_d = ST_IDLE;
          else res_v = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.command)
            CMD_WRITE: begin
              waddr = in_addr;
              wdata = in_val;
              we_a = in_grid && !bank_q;
              we_b = in_grid && bank_q;
              res.range_error = !in_grid;
              res_v = 1'b1;
            end
            CMD_READ: begin
              if (in_grid) begin
                state_d = ST_READ;
              end else begin
                res.range_error = 1'b1;
                res_v = 1'b1;
              end
            end
            CMD_STEP: begin
              state_d = ST_STEP;
              f_d = '0;
              feed_d = 1'b1;
              wa_d = '0;
              wc_d = '0;
              wr_d = '0;
            end
            default: begin
              state_d = ST_CLEAR;
              sweep_d = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        res.cell_state = now_v;
        res.change_code = (now_v != prev_v) ? now_v : CHANGE_UNCHANGED;
        res_v = 1'b1;
      end
      ST_STEP: begin
        raddr = AW'(f_q);
        if (feed_q) begin
          f_d = f_q + FW'(1);
          if (f_q == FW'(N + MAX_ROWS)) feed_d = 1'b0;
        end
        if (wv_q) begin
          waddr = wa_q;
          wdata = interior ? win_next : CELL_EMPTY;
          we_a = bank_q;
          we_b = !bank_q;
          wa_d = wa_q + AW'(1);
          if (wr_q == RIW'(MAX_ROWS - 1)) begin
            wr_d = '0;
            wc_d = wc_q + CIW'(1);
          end else begin
            wr_d = wr_q + RIW'(1);
          end
          if (step_done) begin
            bank_d = !bank_q;
            res_v = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        res = hold_q;
        res_v = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase

    if (res_v) begin
      if (!out_valid_q || out_ready_i) begin
        out_d = res;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end else begin
        hold_d = res;
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      bank_q <= 1'b0;
      cols_q <= RESET_COLUMNS;
      rows_q <= RESET_ROWS;
      sweep_q <= '0;
      f_q <= '0;
      feed_q <= 1'b0;
      s1_v_q <= 1'b0;
      s1_in_q <= 1'b0;
      s1_idx_q <= '0;
      wv_q <= 1'b0;
      wa_q <= '0;
      wc_q <= '0;
      wr_q <= '0;
      hold_q <= '0;
      out_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q <= bank_d;
      cols_q <= cols_d;
      rows_q <= rows_d;
      sweep_q <= sweep_d;
      f_q <= f_d;
      feed_q <= feed_d;
      s1_v_q <= (state_q == ST_STEP) && feed_q;
      s1_in_q <= f_q < FW'(N);
      s1_idx_q <= f_q;
      wv_q <= s1_v_q && (s1_idx_q >= FW'(MAX_ROWS + 1));
      wa_q <= wa_d;
      wc_q <= wc_d;
      wr_q <= wr_d;
      hold_q <= hold_d;
      out_q <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LGE_ASSERT_NEXT(a_step_flips_bank, step_done, bank_q != $past(bank_q), "step did not swap banks")
  `LGE_ASSERT(a_step_one_bank, (state_q == ST_STEP) |-> !(we_a && we_b), "step wrote both banks")
  `LGE_ASSERT_NEXT(a_read_waits_ram, accept && (in_data_i.command == CMD_READ) && in_grid, state_q == ST_READ, "read did not wait for data")
endmodule

// ----- src/lge_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module lge_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- src/lge_window.sv -----
// Sliding three-column window of alive bits and the life rule for its centre cell.
module lge_window #(
  parameter int MAX_ROWS = 128
) (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic       alive_i,
  output logic [1:0] next_o
);
  import lge_pkg::*;

  localparam int L = 2 * MAX_ROWS + 3;

  logic [L-1:0] sh_q;
  logic [3:0]   count;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sh_q <= {sh_q[L-2:0], alive_i};
    end
  end

  assign count = 4'(sh_q[0]) + 4'(sh_q[1]) + 4'(sh_q[2])
               + 4'(sh_q[MAX_ROWS]) + 4'(sh_q[MAX_ROWS+2])
               + 4'(sh_q[2*MAX_ROWS]) + 4'(sh_q[2*MAX_ROWS+1]) + 4'(sh_q[2*MAX_ROWS+2]);

  always_comb begin
    if (sh_q[MAX_ROWS+1]) begin
      next_o = (count == 4'd2 || count == 4'd3) ? CELL_ALIVE : CELL_DIED;
    end else begin
      next_o = (count == 4'd3) ? CELL_ALIVE : CELL_EMPTY;
    end
  end
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the life generation engine: directed table, then random requests.
module tb;
  import lge_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = DEF_MAX_COLUMNS;
  localparam int NROWS = DEF_MAX_ROWS;
  localparam int NCELLS = NCOLS * NROWS;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } table_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_t  in_data_i;
  out_t out_data_o;
  logic cfg_we_i, cfg_index_i;
  logic [7:0] cfg_data_i;

  life_generation_engine dut (.*);

  logic [1:0] grid_bank [2][NCELLS];
  bit         live_bank;
  logic [7:0] columns_reg, rows_reg;

  out_t       pending_results [$];
  table_row_t stim_table [$];
  int         errors, checked, reads_seen, steps_sent, clears_sent, range_hits;
  int         hold_off_cycles;

  function automatic int eff_size(logic [7:0] v, int maxv);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Applies one request to the shadow grid and returns the result it yields.
  function automatic out_t life_apply(in_t r);
    out_t res;
    int cols, rows, n, idx;
    logic [1:0] v, cur, prev;
    cols = eff_size(columns_reg, NCOLS);
    rows = eff_size(rows_reg, NROWS);
    res = '0;
    v = (r.cell_value == CELL_BAD) ? CELL_EMPTY : r.cell_value;
    idx = r.column * NROWS + r.row;
    case (r.command)
      CMD_WRITE: begin
        if (r.column < cols && r.row < rows) grid_bank[live_bank][idx] = v;
        else res.range_error = 1'b1;
      end
      CMD_STEP: begin
        for (int c = 0; c < NCOLS; c++) begin
          for (int w = 0; w < NROWS; w++) begin
            v = CELL_EMPTY;
            if (c >= 1 && c + 1 < cols && w >= 1 && w + 1 < rows) begin
              n = 0;
              for (int dc = -1; dc <= 1; dc++)
                for (int dw = -1; dw <= 1; dw++)
                  if ((dc != 0 || dw != 0) &&
                      grid_bank[live_bank][(c + dc) * NROWS + w + dw] == CELL_ALIVE) n++;
              if (grid_bank[live_bank][c * NROWS + w] == CELL_ALIVE)
                v = (n == 2 || n == 3) ? CELL_ALIVE : CELL_DIED;
              else
                v = (n == 3) ? CELL_ALIVE : CELL_EMPTY;
            end
            grid_bank[!live_bank][c * NROWS + w] = v;
          end
        end
        live_bank = !live_bank;
      end
      CMD_READ: begin
        if (r.column < cols && r.row < rows) begin
          cur = grid_bank[live_bank][idx];
          prev = grid_bank[!live_bank][idx];
          res.cell_state = cur;
          res.change_code = (cur != prev) ? cur : CHANGE_UNCHANGED;
        end else begin
          res.range_error = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < NCELLS; i++) begin
          grid_bank[0][i] = CELL_EMPTY;
          grid_bank[1][i] = CELL_EMPTY;
        end
        live_bank = 1'b0;
      end
    endcase
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #12ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: stalls in its own pattern and honours long hold-offs.
  initial begin
    int phase_cnt;
    out_t want;
    out_ready_i = 1'b0;
    phase_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_data_o.cell_state !== want.cell_state) begin
            $display("%0t: cell_state expected %0d actual %0d", $time,
                     want.cell_state, out_data_o.cell_state);
            errors++;
          end
          if (out_data_o.change_code !== want.change_code) begin
            $display("%0t: change_code expected %0d actual %0d", $time,
                     want.change_code, out_data_o.change_code);
            errors++;
          end
          if (out_data_o.range_error !== want.range_error) begin
            $display("%0t: range_error expected %0d actual %0d", $time,
                     want.range_error, out_data_o.range_error);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        phase_cnt = (phase_cnt + 1) % 96;
        out_ready_i <= (phase_cnt < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == REG_GRID_COLUMNS) columns_reg = val;
    else rows_reg = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offers one request; returns at the edge where it is taken, then maybe pauses.
  task automatic send_request(in_t r, bit typed, out_t want);
    out_t got;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    got = life_apply(r);
    pending_results.push_back(typed ? want : got);
    if (r.command == CMD_READ) reads_seen++;
    if (r.command == CMD_STEP) steps_sent++;
    if (r.command == CMD_CLEAR) clears_sent++;
    if (got.range_error) range_hits++;
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic add_row(logic [1:0] cmd, int c, int r, logic [1:0] v, bit typed,
                         logic [1:0] st, logic [1:0] ch, logic er);
    table_row_t t;
    t.req = '{command: cmd, column: c[6:0], row: r[6:0], cell_value: v};
    t.typed = typed;
    t.want = '{cell_state: st, change_code: ch, range_error: er};
    stim_table.push_back(t);
  endtask

  function automatic in_t random_request(int cols, int rows, ref int steps_left,
                                         ref int clears_left);
    in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.column = $urandom_range(0, cols - 1);
    r.row = $urandom_range(0, rows - 1);
    r.cell_value = ($urandom_range(0, 2) == 0) ? 2'($urandom) : CELL_ALIVE;
    if (pick < 45) r.command = CMD_WRITE;
    else if (pick < 75) r.command = CMD_READ;
    else if (pick < 85) begin
      r.command = pick[0] ? CMD_WRITE : CMD_READ;
      r.column = 7'($urandom);
      r.row = 7'($urandom);
    end else if (pick < 93 && steps_left > 0) begin
      r.command = CMD_STEP;
      steps_left--;
    end else if (pick < 96 && clears_left > 0) begin
      r.command = CMD_CLEAR;
      clears_left--;
    end else r.command = CMD_READ;
    return r;
  endfunction

  initial begin
    logic [7:0] col_set [6] = '{8'd0, 8'd255, 8'd128, 8'd8, 8'd2, 8'd12};
    logic [7:0] row_set [6] = '{8'd1, 8'd255, 8'd3, 8'd10, 8'd128, 8'd9};
    int steps_left, clears_left;
    out_t blank;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_GRID_COLUMNS;
    cfg_data_i = '0;
    errors = 0;
    checked = 0;
    reads_seen = 0;
    steps_sent = 0;
    clears_sent = 0;
    range_hits = 0;
    hold_off_cycles = 0;
    blank = '0;
    columns_reg = RESET_COLUMNS;
    rows_reg = RESET_ROWS;
    live_bank = 1'b0;
    for (int i = 0; i < NCELLS; i++) begin
      grid_bank[0][i] = CELL_EMPTY;
      grid_bank[1][i] = CELL_EMPTY;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_READ, 0, 0, CELL_EMPTY, 1, CELL_EMPTY, CHANGE_UNCHANGED, 0);
    add_row(CMD_READ, 127, 0, CELL_EMPTY, 1, CELL_EMPTY, CELL_EMPTY, 1);
    add_row(CMD_READ, 0, 127, CELL_EMPTY, 1, CELL_EMPTY, CELL_EMPTY, 1);
    add_row(CMD_WRITE, 127, 127, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 1);
    add_row(CMD_WRITE, 5, 5, CELL_BAD, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_READ, 5, 5, CELL_EMPTY, 1, CELL_EMPTY, CHANGE_UNCHANGED, 0);
    add_row(CMD_WRITE, 0, 0, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_WRITE, 10, 9, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_WRITE, 10, 10, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_WRITE, 10, 11, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_WRITE, 20, 20, CELL_DIED, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_WRITE, 105, 79, CELL_ALIVE, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_STEP, 0, 0, CELL_EMPTY, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_READ, 0, 0, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 10, 10, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 9, 10, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 10, 9, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 11, 10, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 20, 20, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 105, 79, CELL_EMPTY, 0, 0, 0, 0);
    add_row(CMD_READ, 106, 79, CELL_EMPTY, 1, CELL_EMPTY, CELL_EMPTY, 1);
    add_row(CMD_CLEAR, 0, 0, CELL_EMPTY, 1, CELL_EMPTY, CELL_EMPTY, 0);
    add_row(CMD_READ, 10, 10, CELL_EMPTY, 1, CELL_EMPTY, CHANGE_UNCHANGED, 0);
    foreach (stim_table[i]) send_request(stim_table[i].req, stim_table[i].typed,
                                         stim_table[i].want);
    in_valid_i <= 1'b0;
    drain();

    foreach (col_set[p]) begin
      write_reg(REG_GRID_COLUMNS, (p == 5) ? 8'($urandom_range(3, 20)) : col_set[p]);
      write_reg(REG_GRID_ROWS, (p == 5) ? 8'($urandom_range(3, 20)) : row_set[p]);
      cfg_we_i <= 1'b0;
      steps_left = 2;
      clears_left = (p % 2);
      for (int k = 0; k < 13; k++) begin
        if (p == 1 && k == 4) hold_off_cycles = 300;
        send_request(random_request(eff_size(columns_reg, NCOLS),
                                    eff_size(rows_reg, NROWS), steps_left, clears_left),
                     0, blank);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    $display("Checked %0d results: %0d reads, %0d steps, %0d clears, %0d range errors.",
             checked, reads_seen, steps_sent, clears_sent, range_hits);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- life_generation_engine.f -----
+incdir+src
src/lge_pkg.sv
src/lge_ram.sv
src/lge_window.sv
src/life_generation_engine.sv
verif/tb.sv
